### rtl/linear_probe_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Linear probe slot allocator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_SLOT_ALLOCATOR_DEFINES_SVH
`define LINEAR_PROBE_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define LPSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpsa check failed");

// next-cycle implication, off during reset
`define LPSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpsa check failed");

// next-cycle implication, live through reset
`define LPSA_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lpsa check failed");

`endif

### rtl/lpsa_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe slot allocator package
// Sizes, widths and controller states shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsa_pkg;

  localparam int SLOTS     = 1024;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int SIZE_W    = 11;
  localparam int ID_W      = 31;
  localparam int OUT_IDX_W = 10;

  localparam int ROW_BITS  = 32;
  localparam int ROW_W     = $clog2(ROW_BITS);
  localparam int ROWS      = SLOTS / ROW_BITS;
  localparam int RADDR_W   = $clog2(ROWS);

  localparam int DIV_STEPS = (ID_W + 1) / 2;
  localparam int DIV_PAD_W = 2 * DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_PROBE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/lpsa_mod.sv
// ----------------------------------------------------------------------------
// Linear probe slot allocator home slot unit
// Restoring remainder of the user id by the table size, two bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsa_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lpsa_pkg::ID_W-1:0]     dividend,
  input  logic [lpsa_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [lpsa_pkg::IDX_W-1:0]    remainder
);

  logic                              busy;
  logic [lpsa_pkg::DIV_CNT_W-1:0]    cnt;
  logic [lpsa_pkg::DIV_PAD_W-1:0]    shreg;
  logic [lpsa_pkg::SIZE_W-1:0]       dvsr;
  logic [lpsa_pkg::SIZE_W-1:0]       rem;
  logic [lpsa_pkg::SIZE_W-1:0]       rem_a;
  logic [lpsa_pkg::SIZE_W-1:0]       rem_b;

  function automatic logic [lpsa_pkg::SIZE_W-1:0] rem_step(
    input logic [lpsa_pkg::SIZE_W-1:0] r,
    input logic                        b,
    input logic [lpsa_pkg::SIZE_W-1:0] d
  );
    logic [lpsa_pkg::SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[lpsa_pkg::SIZE_W-1:0];
  endfunction

  assign rem_a     = rem_step(rem, shreg[lpsa_pkg::DIV_PAD_W-1], dvsr);
  assign rem_b     = rem_step(rem_a, shreg[lpsa_pkg::DIV_PAD_W-2], dvsr);
  assign remainder = rem[lpsa_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= lpsa_pkg::DIV_CNT_W'(lpsa_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= lpsa_pkg::DIV_PAD_W'(dividend);
      dvsr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[lpsa_pkg::DIV_PAD_W-3:0], 2'b00};
      rem   <= rem_b;
    end
  end

endmodule

`default_nettype wire

### rtl/linear_probe_slot_allocator.sv
// ----------------------------------------------------------------------------
// Linear probe slot allocator
// Grants the first free slot at or after user_id mod table_size, wrapping.
// ----------------------------------------------------------------------------
// One request is handled at a time. A new request is taken only once the
// previous one has passed through these steps and is back in idle:
//   - the home slot remainder (two quotient bits a cycle, then the result
//     handed over);
//   - the first row read issued;
//   - the 32-slot rows probed in turn from the home row (up to 33 rows when the
//     table is full or nearly so);
//   - the grant posted;
//   - a return to idle.
// The occupancy bitmap sits in a 32x32 single-port memory with per-row valid
// flags, so a batch end frees the whole table at once and no clearing pass
// follows reset. A grant waiting in the output register does not block the
// next request from being taken. That request holds its own grant until the
// output register frees, and every stalled cycle there adds to its time.
// A table_size write is taken only in idle with no request offered.
`default_nettype none

module linear_probe_slot_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lpsa_pkg::ID_W-1:0]         user_id,
  input  logic                              last_request,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lpsa_pkg::OUT_IDX_W-1:0]    slot_index,
  output logic                              table_full,
  output logic                              last_grant,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpsa_pkg::SIZE_W-1:0]       table_size
);

  lpsa_pkg::state_t state, state_next;

  logic [lpsa_pkg::SIZE_W-1:0]   size_reg;
  logic [lpsa_pkg::SIZE_W-1:0]   eff_size;
  logic [lpsa_pkg::IDX_W-1:0]    lim_idx;
  logic [lpsa_pkg::RADDR_W-1:0]  last_row;
  logic [lpsa_pkg::ROW_W-1:0]    last_bit;

  logic                          in_take;
  logic                          last_r;
  logic                          div_done;
  logic [lpsa_pkg::IDX_W-1:0]    home;

  logic [lpsa_pkg::RADDR_W-1:0]  row;
  logic [lpsa_pkg::RADDR_W-1:0]  start_row;
  logic [lpsa_pkg::ROW_W-1:0]    start_bit;
  logic                          first;
  logic                          wrapped;

  logic [lpsa_pkg::ROW_BITS-1:0] mem [lpsa_pkg::ROWS];
  logic [lpsa_pkg::ROWS-1:0]     row_valid;
  logic [lpsa_pkg::ROW_BITS-1:0] rdata;
  logic                          rvalid;
  logic                          rd_en;
  logic [lpsa_pkg::RADDR_W-1:0]  rd_addr;

  logic [lpsa_pkg::ROW_BITS-1:0] word;
  logic [lpsa_pkg::ROW_BITS-1:0] smask;
  logic [lpsa_pkg::ROW_BITS-1:0] lmask;
  logic [lpsa_pkg::ROW_BITS-1:0] cand;
  logic [lpsa_pkg::ROW_W-1:0]    hit_bit;
  logic                          hit;
  logic                          give_up;
  logic [lpsa_pkg::RADDR_W-1:0]  row_next;
  logic                          load_out;

  logic [lpsa_pkg::IDX_W-1:0]    res_idx;
  logic                          res_full;
  logic [lpsa_pkg::ROW_BITS-1:0] wword;

  assign in_stall  = (state != lpsa_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state == lpsa_pkg::ST_IDLE) && !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= lpsa_pkg::SIZE_W'(lpsa_pkg::SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= table_size;
    end
  end

  always_comb begin
    eff_size = size_reg;
    if (size_reg == '0) begin
      eff_size = lpsa_pkg::SIZE_W'(1);
    end else if (size_reg > lpsa_pkg::SIZE_W'(lpsa_pkg::SLOTS)) begin
      eff_size = lpsa_pkg::SIZE_W'(lpsa_pkg::SLOTS);
    end
  end

  assign lim_idx  = lpsa_pkg::IDX_W'(eff_size - 1'b1);
  assign last_row = lim_idx[lpsa_pkg::IDX_W-1:lpsa_pkg::ROW_W];
  assign last_bit = lim_idx[lpsa_pkg::ROW_W-1:0];

  lpsa_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (in_take),
    .dividend  (user_id),
    .divisor   (eff_size),
    .done      (div_done),
    .remainder (home)
  );

  // row probe
  assign word  = rvalid ? rdata : '0;
  assign smask = first ? ({lpsa_pkg::ROW_BITS{1'b1}} << start_bit)
                       : {lpsa_pkg::ROW_BITS{1'b1}};
  assign lmask = (row == last_row)
               ? ({lpsa_pkg::ROW_BITS{1'b1}} >>
                  (lpsa_pkg::ROW_W'(lpsa_pkg::ROW_BITS - 1) - last_bit))
               : {lpsa_pkg::ROW_BITS{1'b1}};
  assign cand  = ~word & smask & lmask;
  assign hit   = |cand;
  assign give_up  = !hit && wrapped && (row == start_row);
  assign row_next = (row == last_row) ? '0 : row + 1'b1;

  always_comb begin
    hit_bit = '0;
    for (int i = lpsa_pkg::ROW_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_bit = lpsa_pkg::ROW_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = row;
    load_out   = 1'b0;
    unique case (state)
      lpsa_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = lpsa_pkg::ST_DIV;
        end
      end
      lpsa_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lpsa_pkg::ST_READ;
        end
      end
      lpsa_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = lpsa_pkg::ST_PROBE;
      end
      lpsa_pkg::ST_PROBE: begin
        if (hit || give_up) begin
          state_next = lpsa_pkg::ST_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = row_next;
        end
      end
      lpsa_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = lpsa_pkg::ST_IDLE;
        end
      end
      default: state_next = lpsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      last_r <= last_request;
    end
    if (div_done) begin
      row       <= home[lpsa_pkg::IDX_W-1:lpsa_pkg::ROW_W];
      start_row <= home[lpsa_pkg::IDX_W-1:lpsa_pkg::ROW_W];
      start_bit <= home[lpsa_pkg::ROW_W-1:0];
      first     <= 1'b1;
      wrapped   <= 1'b0;
    end
    if (state == lpsa_pkg::ST_PROBE) begin
      if (hit) begin
        res_idx  <= {row, hit_bit};
        res_full <= 1'b0;
        wword    <= word | (lpsa_pkg::ROW_BITS'(1) << hit_bit);
      end else if (give_up) begin
        res_idx  <= '0;
        res_full <= 1'b1;
      end else begin
        row     <= row_next;
        first   <= 1'b0;
        wrapped <= wrapped || (row == last_row);
      end
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (load_out && !res_full) begin
      mem[row] <= wword;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid    <= 1'b0;
    end else begin
      if (rd_en) begin
        rvalid <= row_valid[rd_addr];
      end
      if (load_out) begin
        if (last_r) begin
          row_valid <= '0;
        end else if (!res_full) begin
          row_valid[row] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      slot_index <= lpsa_pkg::OUT_IDX_W'(res_idx);
      table_full <= res_full;
      last_grant <= last_r;
    end
  end

endmodule

`default_nettype wire

### rtl/lpsa_check.sv
// ----------------------------------------------------------------------------
// Linear probe slot allocator port checker
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_slot_allocator_defines.svh"

module lpsa_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [lpsa_pkg::OUT_IDX_W-1:0]    slot_index,
  input  logic                              table_full,
  input  logic                              last_grant
);

  `LPSA_ASSERT_NOW(a_full_zero_index, out_valid && table_full, slot_index == '0)
  `LPSA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `LPSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LPSA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(slot_index) && $stable(table_full) && $stable(last_grant))
  `LPSA_ASSERT_ALWAYS(a_reset_idle, rst, !out_valid && !in_stall)

endmodule

bind linear_probe_slot_allocator lpsa_check u_lpsa_check (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Linear probe slot allocator testbench
// Directed and random requests are pushed through the allocator while a local
// occupancy bitmap predicts every grant. The sender runs in bursts with gaps,
// the receiver stalls in changing patterns, and table_size is rewritten
// between phases. A phase may end without closing its batch, so the next
// size applies to a partly filled table.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int ITEMS       = 1800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [lpsa_pkg::ID_W-1:0] user_id;
    logic                      last_request;
  } request_t;

  typedef struct packed {
    logic [lpsa_pkg::OUT_IDX_W-1:0] slot_index;
    logic                           table_full;
    logic                           last_grant;
  } grant_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [lpsa_pkg::ID_W-1:0]   user_id = '0;
  logic              last_request = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [lpsa_pkg::OUT_IDX_W-1:0] slot_index;
  logic              table_full;
  logic              last_grant;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [lpsa_pkg::SIZE_W-1:0] table_size = 11'd1024;

  request_t    request_queue[$];
  grant_t      pending_grants[$];
  logic [lpsa_pkg::SLOTS-1:0] slot_taken = '0;
  logic [lpsa_pkg::SIZE_W-1:0] cfg_table_size = 11'd1024;

  int          cycles = 0;
  int          mismatches = 0;
  int          requests_in = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  request_t    next_req;
  grant_t      got_grant;
  grant_t      want_grant;

  linear_probe_slot_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .user_id      (user_id),
    .last_request (last_request),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .table_full   (table_full),
    .last_grant   (last_grant),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .table_size   (table_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic grant_t allocate_slot(logic [lpsa_pkg::ID_W-1:0] id, logic last);
    grant_t      g;
    int unsigned span;
    int unsigned pos;
    int unsigned n;
    bit          found;
    span = cfg_table_size;
    if (span == 0) span = 1;
    if (span > lpsa_pkg::SLOTS) span = lpsa_pkg::SLOTS;
    pos = id % span;
    found = 1'b0;
    g = '0;
    for (n = 0; n < span && !found; n++) begin
      if (!slot_taken[pos]) found = 1'b1;
      else pos = (pos + 1 == span) ? 0 : pos + 1;
    end
    if (found) begin
      slot_taken[pos] = 1'b1;
      g.slot_index = pos[lpsa_pkg::OUT_IDX_W-1:0];
    end else begin
      g.table_full = 1'b1;
    end
    g.last_grant = last;
    if (last) slot_taken = '0;
    return g;
  endfunction

  // sender: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_grants.insert(pending_grants.size(), allocate_slot(user_id, last_request));
        requests_in <= requests_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          next_req = request_queue.pop_front();
          user_id <= next_req.user_id;
          last_request <= next_req.last_request;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && in_valid && request_queue.size() >= 8 &&
          requests_in >= (holds_done == 0 ? 300 : 1200)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= cycles[2];
        endcase
      end
    end
  end

  // compare each grant with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_grant = '{slot_index: slot_index, table_full: table_full, last_grant: last_grant};
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected grant slot_index %0d table_full %0d last_grant %0d",
                 $time, slot_index, table_full, last_grant);
        mismatches++;
      end else begin
        want_grant = pending_grants.pop_front();
        if (got_grant.slot_index !== want_grant.slot_index) begin
          $display("%0t slot_index expected %0d actual %0d",
                   $time, want_grant.slot_index, got_grant.slot_index);
          mismatches++;
        end
        if (got_grant.table_full !== want_grant.table_full) begin
          $display("%0t table_full expected %0d actual %0d",
                   $time, want_grant.table_full, got_grant.table_full);
          mismatches++;
        end
        if (got_grant.last_grant !== want_grant.last_grant) begin
          $display("%0t last_grant expected %0d actual %0d",
                   $time, want_grant.last_grant, got_grant.last_grant);
          mismatches++;
        end
      end
    end
  end

  task automatic push_request(logic [lpsa_pkg::ID_W-1:0] id, logic last);
    request_t r;
    r.user_id = id;
    r.last_request = last;
    request_queue.insert(request_queue.size(), r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || pending_grants.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_table_size(logic [lpsa_pkg::SIZE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    table_size <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_table_size = value;
  endtask

  initial begin
    int unsigned      queued;
    int unsigned      span;
    int unsigned      batches;
    int unsigned      len;
    int unsigned      anchor;
    int unsigned      b;
    int unsigned      k;
    logic [lpsa_pkg::SIZE_W-1:0] new_size;
    logic [lpsa_pkg::ID_W-1:0]   id;
    logic             last;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_request(31'd0, 1'b0);
    push_request(31'h7fff_ffff, 1'b0);
    push_request(31'd1023, 1'b0);
    push_request(31'd1024, 1'b0);
    push_request(31'h4000_0000, 1'b0);
    push_request(31'h2aaa_aaaa, 1'b0);
    push_request(31'h5555_5555, 1'b1);
    wait_idle();

    write_table_size(11'd0);
    push_request(31'd5, 1'b0);
    push_request(31'd9, 1'b0);
    push_request(31'd0, 1'b1);
    wait_idle();

    write_table_size(11'd2047);
    push_request(31'h7fff_ffff, 1'b0);
    push_request(31'd1, 1'b1);
    wait_idle();

    write_table_size(11'd3);
    repeat (3) push_request(31'd2, 1'b0);
    push_request(31'd2, 1'b1);
    wait_idle();

    // shrink and regrow the table inside one batch
    write_table_size(11'd8);
    push_request(31'd7, 1'b0);
    push_request(31'd15, 1'b0);
    push_request(31'd6, 1'b0);
    wait_idle();
    write_table_size(11'd4);
    push_request(31'd3, 1'b0);
    push_request(31'd3, 1'b0);
    push_request(31'd2, 1'b0);
    push_request(31'd1, 1'b0);
    wait_idle();
    write_table_size(11'd8);
    push_request(31'd7, 1'b1);
    wait_idle();

    queued = 24;
    while (queued < ITEMS) begin
      case ($urandom_range(0, 19))
        0:          new_size = 11'd0;
        1:          new_size = 11'd2047;
        2:          new_size = 11'd1024;
        3, 4, 5:    new_size = lpsa_pkg::SIZE_W'($urandom_range(65, 1023));
        default:    new_size = lpsa_pkg::SIZE_W'($urandom_range(1, 64));
      endcase
      write_table_size(new_size);
      span = (new_size == 0) ? 1
           : ((new_size > lpsa_pkg::SLOTS) ? lpsa_pkg::SLOTS : new_size);
      batches = $urandom_range(1, 3);
      for (b = 0; b < batches; b++) begin
        len = (span <= 64) ? $urandom_range(1, span + 4) : $urandom_range(4, 48);
        anchor = $urandom_range(0, span - 1);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 3))
            0:       id = lpsa_pkg::ID_W'($urandom);
            1:       id = lpsa_pkg::ID_W'($urandom_range(0, 2 * span));
            default: id = lpsa_pkg::ID_W'(anchor + $urandom_range(0, 3) +
                                          span * $urandom_range(0, 100000));
          endcase
          if (k == len - 1) last = (b != batches - 1) || ($urandom_range(0, 3) != 0);
          else last = ($urandom_range(0, 39) == 0);
          push_request(id, last);
          queued++;
        end
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
